// File: rtl/core/neighbor_cell_usage_monitor_core_assert.svh
// assertion macros shared by the monitor rtl
`ifndef NEIGHBOR_CELL_USAGE_MONITOR_CORE_ASSERT_SVH
`define NEIGHBOR_CELL_USAGE_MONITOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NCUM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ncum same-cycle check failed");

// next-cycle implication, checked out of reset
`define NCUM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ncum next-cycle check failed");

`endif

// File: rtl/core/ncum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ncum_pkg;

  localparam int NBR_W            = 4;
  localparam int TYPE_W           = 2;
  localparam int CNT_W            = 10;
  localparam int LIMIT_W          = 9;
  localparam int INC_W            = 4;
  localparam int PROD_W           = LIMIT_W + CNT_W;
  localparam int FRAC_W           = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 10;
  localparam int IN_TDATA_W       = 8;
  localparam int OUT_TDATA_W      = 16;
  localparam int NBR_TABLE_MAX    = 2 ** NBR_W;
  localparam int NEIGHBORS_DEFAULT = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX            = '1;
  localparam logic [CNT_W-1:0]   WINDOW_RESET       = CNT_W'(100);
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET   = LIMIT_W'(192);
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET    = LIMIT_W'(64);
  localparam logic [INC_W-1:0]   ADD_INCREMENT_RESET = INC_W'(1);

  typedef enum logic [TYPE_W-1:0] {
    REQ_SLOT  = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_ACK   = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_CELLS_WINDOW = 2'd0,
    CFG_USAGE_HIGH_LIMIT = 2'd1,
    CFG_USAGE_LOW_LIMIT  = 2'd2,
    CFG_ADD_INCREMENT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]   max_cells_window;
    logic [LIMIT_W-1:0] usage_high_limit;
    logic [LIMIT_W-1:0] usage_low_limit;
    logic [INC_W-1:0]   add_increment;
  } cfg_t;

  typedef struct packed {
    logic               assessed;
    logic               add_request;
    logic [INC_W-1:0]   add_count;
    logic               delete_request;
    logic [CNT_W-1:0]   elapsed_next;
    logic [CNT_W-1:0]   used_next;
  } assess_t;

endpackage
`default_nettype wire

// File: rtl/core/ncum_assess.sv
`timescale 1ns / 1ps
`default_nettype none
module ncum_assess (
  input  wire logic                          in_range,
  input  wire logic [ncum_pkg::TYPE_W-1:0]   req_type,
  input  wire logic [ncum_pkg::CNT_W-1:0]    elapsed,
  input  wire logic [ncum_pkg::CNT_W-1:0]    used,
  input  wire ncum_pkg::cfg_t                cfg,
  output ncum_pkg::assess_t                  res
);
  import ncum_pkg::*;

  logic [CNT_W-1:0]  elapsed_inc;
  logic [CNT_W-1:0]  used_inc;
  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] high_prod;
  logic [PROD_W-1:0] low_prod;
  logic              hit;
  logic              nonzero;
  logic              add_hit;

  always_comb begin
    elapsed_inc = elapsed;
    used_inc    = used;
    case (req_type)
      REQ_SLOT: begin
        if (elapsed != CNT_MAX) elapsed_inc = elapsed + CNT_W'(1);
      end
      REQ_FRAME: begin
        if (used != CNT_MAX) used_inc = used + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // usage in q1.8 compared without division
  assign scaled    = PROD_W'({used_inc, {FRAC_W{1'b0}}});
  assign high_prod = PROD_W'(cfg.usage_high_limit) * PROD_W'(elapsed_inc);
  assign low_prod  = PROD_W'(cfg.usage_low_limit) * PROD_W'(elapsed_inc);

  assign hit     = in_range && (elapsed_inc >= cfg.max_cells_window);
  assign nonzero = (elapsed_inc != '0);
  assign add_hit = hit && nonzero && (scaled >= high_prod);

  always_comb begin
    res.assessed       = hit;
    res.add_request    = add_hit;
    res.add_count      = add_hit ? cfg.add_increment : '0;
    res.delete_request = hit && nonzero && (scaled <= low_prod);
    res.elapsed_next   = hit ? '0 : elapsed_inc;
    res.used_next      = hit ? '0 : used_inc;
  end

endmodule
`default_nettype wire

// File: rtl/core/neighbor_cell_usage_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  signals                               contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser     neighbor event
// m_*       out  m_tvalid m_tready m_tdata             assessment result
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data register write
//
// one transaction per cycle sustained while the result side is not stalled;
// an accepted input transaction passes the input register then the result
// register, counter read-modify-write between them
// rst is synchronous; it clears both counter tables and loads register defaults
// a stalled result holds the input register; cfg_ready is always high
module neighbor_cell_usage_monitor_core #(
  parameter int NEIGHBORS = ncum_pkg::NEIGHBORS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [3:0] neighbor_index, [7:4] zero
  input  wire logic [ncum_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [1:0] req_type
  input  wire logic [ncum_pkg::TYPE_W-1:0]        s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [3:0] target_neighbor, [4] assessed, [5] add_request, [9:6] add_count,
  // [10] delete_request, [15:11] zero
  output logic [ncum_pkg::OUT_TDATA_W-1:0]        m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ncum_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ncum_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ncum_pkg::*;

  localparam int DEPTH = (NEIGHBORS < NBR_TABLE_MAX) ? NEIGHBORS : NBR_TABLE_MAX;
  localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  logic              s1_valid;
  logic [NBR_W-1:0]  s1_idx;
  logic [TYPE_W-1:0] s1_type;
  logic              advance;
  logic              in_range;
  logic [SEL_W-1:0]  sel;
  logic [CNT_W-1:0]  elapsed_count [DEPTH];
  logic [CNT_W-1:0]  used_count [DEPTH];
  logic [CNT_W-1:0]  elapsed_rd;
  logic [CNT_W-1:0]  used_rd;
  assess_t           res;
  logic [NBR_W-1:0]  target_neighbor;
  logic              assessed;
  logic              add_request;
  logic [INC_W-1:0]  add_count;
  logic              delete_request;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_cells_window <= WINDOW_RESET;
      cfg.usage_high_limit <= HIGH_LIMIT_RESET;
      cfg.usage_low_limit  <= LOW_LIMIT_RESET;
      cfg.add_increment    <= ADD_INCREMENT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_MAX_CELLS_WINDOW: cfg.max_cells_window <= cfg_data;
        CFG_USAGE_HIGH_LIMIT: cfg.usage_high_limit <= cfg_data[LIMIT_W-1:0];
        CFG_USAGE_LOW_LIMIT:  cfg.usage_low_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_ADD_INCREMENT:    cfg.add_increment    <= cfg_data[INC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_idx  <= s_tdata[NBR_W-1:0];
      s1_type <= s_tuser;
    end
  end

  assign in_range = (int'(s1_idx) < DEPTH);
  assign sel      = SEL_W'(s1_idx);

  always_comb begin
    elapsed_rd = '0;
    used_rd    = '0;
    if (in_range) begin
      elapsed_rd = elapsed_count[sel];
      used_rd    = used_count[sel];
    end
  end

  ncum_assess u_assess (
    .in_range (in_range),
    .req_type (s1_type),
    .elapsed  (elapsed_rd),
    .used     (used_rd),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        elapsed_count[i] <= '0;
        used_count[i]    <= '0;
      end
    end else if (advance && in_range) begin
      elapsed_count[sel] <= res.elapsed_next;
      used_count[sel]    <= res.used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      target_neighbor <= s1_idx;
      assessed        <= res.assessed;
      add_request     <= res.add_request;
      add_count       <= res.add_count;
      delete_request  <= res.delete_request;
    end
  end

  assign m_tdata = OUT_TDATA_W'({delete_request, add_count, add_request, assessed,
                                 target_neighbor});

  `include "neighbor_cell_usage_monitor_core_assert.svh"

  `NCUM_ASSERT_NEXT(a_result_follows, advance, m_tvalid)
  `NCUM_ASSERT_NOW(a_flags_need_assess, m_tvalid && (add_request || delete_request), assessed)
  `NCUM_ASSERT_NOW(a_count_with_add, m_tvalid && !add_request, add_count == '0)
  `NCUM_ASSERT_NOW(a_out_of_range_quiet, s1_valid && !in_range, !res.assessed)
  `NCUM_ASSERT_NOW(a_accept_frees_input, s_tvalid && s_tready && s1_valid, advance)

endmodule
`default_nettype wire

// File: tb/neighbor_cell_usage_monitor_core_tb.sv
`timescale 1ns / 1ps
module neighbor_cell_usage_monitor_core_tb;
  import ncum_pkg::*;

  localparam int NEIGHBORS = NEIGHBORS_DEFAULT;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  // m_tdata layout from the top bit down
  typedef struct packed {
    logic               delete_request;
    logic [INC_W-1:0]   add_count;
    logic               add_request;
    logic               assessed;
    logic [NBR_W-1:0]   target_neighbor;
  } usage_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [TYPE_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the block's registers and counter tables
  logic [CNT_W-1:0] window_len;
  logic [LIMIT_W-1:0] high_limit;
  logic [LIMIT_W-1:0] low_limit;
  logic [INC_W-1:0] add_step;
  logic [CNT_W-1:0] slots_seen [NEIGHBORS];
  logic [CNT_W-1:0] frames_sent [NEIGHBORS];

  usage_verdict_t pending_verdicts[$];
  bit idling = 1'b1;
  int errors = 0;
  int events_in = 0;
  int verdicts_out = 0;
  int assessments = 0;
  int adds = 0;
  int deletes = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  neighbor_cell_usage_monitor_core #(
    .NEIGHBORS(NEIGHBORS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic usage_verdict_t assess_event(logic [NBR_W-1:0] nbr,
                                                  logic [TYPE_W-1:0] kind);
    usage_verdict_t v;
    int unsigned elapsed;
    int unsigned scaled;
    v = '0;
    v.target_neighbor = nbr;
    if (int'(nbr) < NEIGHBORS) begin
      if (kind == REQ_SLOT) begin
        if (slots_seen[nbr] != CNT_MAX) slots_seen[nbr] = slots_seen[nbr] + 1'b1;
      end else if (kind == REQ_FRAME) begin
        if (frames_sent[nbr] != CNT_MAX) frames_sent[nbr] = frames_sent[nbr] + 1'b1;
      end
      if (slots_seen[nbr] >= window_len) begin
        elapsed = slots_seen[nbr];
        scaled = frames_sent[nbr] << FRAC_W;
        v.assessed = 1'b1;
        // no usage when nothing elapsed
        if (elapsed != 0) begin
          v.add_request = scaled >= high_limit * elapsed;
          v.delete_request = scaled <= low_limit * elapsed;
        end
        slots_seen[nbr] = '0;
        frames_sent[nbr] = '0;
      end
    end
    v.add_count = v.add_request ? add_step : '0;
    return v;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // scoreboard: results first, then the event accepted at this edge
  always @(posedge clk) begin
    usage_verdict_t want;
    usage_verdict_t got;
    usage_verdict_t fresh;
    if (rst) begin
      window_len = WINDOW_RESET;
      high_limit = HIGH_LIMIT_RESET;
      low_limit = LOW_LIMIT_RESET;
      add_step = ADD_INCREMENT_RESET;
      for (int i = 0; i < NEIGHBORS; i++) begin
        slots_seen[i] = '0;
        frames_sent[i] = '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(usage_verdict_t)-1:0];
        verdicts_out++;
        if (pending_verdicts.size() == 0) begin
          errors++;
          $error("result with nothing expected: m_tdata %h", m_tdata);
        end else begin
          want = pending_verdicts.pop_front();
          check_field("target_neighbor", want.target_neighbor, got.target_neighbor);
          check_field("assessed", want.assessed, got.assessed);
          check_field("add_request", want.add_request, got.add_request);
          check_field("add_count", want.add_count, got.add_count);
          check_field("delete_request", want.delete_request, got.delete_request);
          if (want.assessed) assessments++;
          if (want.add_request) adds++;
          if (want.delete_request) deletes++;
        end
      end
      if (s_tvalid && s_tready) begin
        fresh = assess_event(s_tdata[NBR_W-1:0], s_tuser);
        pending_verdicts = {pending_verdicts, fresh};
        events_in++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          CFG_MAX_CELLS_WINDOW: window_len = cfg_data[CNT_W-1:0];
          CFG_USAGE_HIGH_LIMIT: high_limit = cfg_data[LIMIT_W-1:0];
          CFG_USAGE_LOW_LIMIT: low_limit = cfg_data[LIMIT_W-1:0];
          CFG_ADD_INCREMENT: add_step = cfg_data[INC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("neighbor_cell_usage_monitor_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(logic [NBR_W-1:0] nbr, logic [TYPE_W-1:0] kind);
    int gap;
    if (idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'(nbr);
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_e which, int unsigned value);
    cfg_index <= which;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(int unsigned window, int unsigned high, int unsigned low,
                             int unsigned step);
    settle();
    cfg_valid <= 1'b1;
    put_reg(CFG_MAX_CELLS_WINDOW, window);
    put_reg(CFG_USAGE_HIGH_LIMIT, high);
    put_reg(CFG_USAGE_LOW_LIMIT, low);
    put_reg(CFG_ADD_INCREMENT, step);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TYPE_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_SLOT;
    if (r < 88) return REQ_FRAME;
    if (r < 96) return REQ_ACK;
    return REQ_UNUSED;
  endfunction

  function automatic int unsigned pick_limit();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 511;
      2: return $urandom_range(0, 511);
      default: return $urandom_range(0, 256);
    endcase
  endfunction

  // reset window of 100 keeps everything unassessed
  task automatic test_reset_defaults();
    send_event(4'd9, REQ_ACK);
    send_event(4'd9, REQ_UNUSED);
    send_event(4'd9, REQ_FRAME);
    send_event(4'd9, REQ_SLOT);
    send_event(4'd0, REQ_SLOT);
  endtask

  task automatic test_event_kinds();
    load_config(4, 192, 64, 15);
    // usage exactly at the high limit
    send_event(4'd15, REQ_FRAME);
    send_event(4'd15, REQ_FRAME);
    send_event(4'd15, REQ_FRAME);
    send_event(4'd15, REQ_SLOT);
    send_event(4'd15, REQ_ACK);
    send_event(4'd15, REQ_SLOT);
    send_event(4'd15, REQ_UNUSED);
    send_event(4'd15, REQ_SLOT);
    send_event(4'd15, REQ_SLOT);
    // idle neighbor goes below the low limit
    send_event(4'd1, REQ_SLOT);
    send_event(4'd1, REQ_SLOT);
    send_event(4'd1, REQ_SLOT);
    send_event(4'd1, REQ_SLOT);
  endtask

  task automatic test_zero_window_and_overlap();
    load_config(0, 0, 511, 0);
    send_event(4'd5, REQ_ACK);
    send_event(4'd5, REQ_FRAME);
    send_event(4'd5, REQ_SLOT);
    send_event(4'd5, REQ_UNUSED);
    load_config(1, 256, 0, 15);
    send_event(4'd6, REQ_FRAME);
    send_event(4'd6, REQ_SLOT);
    send_event(4'd6, REQ_SLOT);
  endtask

  // widest window keeps a busy neighbor unassessed until the next phase
  task automatic test_wide_window();
    load_config(1023, 256, 256, 15);
    repeat (8) send_event(4'd12, REQ_FRAME);
    repeat (12) send_event(4'd12, REQ_SLOT);
  endtask

  task automatic send_traffic(int count);
    int base;
    logic [NBR_W-1:0] nbr;
    base = $urandom_range(0, NEIGHBORS - 1);
    repeat (count) begin
      if ($urandom_range(0, 4) != 0) nbr = NBR_W'(base + $urandom_range(0, 2));
      else nbr = NBR_W'($urandom_range(0, NEIGHBORS - 1));
      send_event(nbr, pick_kind());
    end
  endtask

  task automatic test_random_traffic();
    int unsigned window;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 5))
        0: window = 1;
        1: window = 0;
        2: window = $urandom_range(9, 40);
        default: window = $urandom_range(2, 8);
      endcase
      load_config(window, pick_limit(), pick_limit(), $urandom_range(0, 15));
      send_traffic(130);
    end
  endtask

  task automatic test_back_to_back();
    idling = 1'b0;
    load_config($urandom_range(1, 6), pick_limit(), pick_limit(), $urandom_range(0, 15));
    send_traffic(150);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_event_kinds();
    test_zero_window_and_overlap();
    test_wide_window();
    test_random_traffic();
    test_back_to_back();
    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d events and %0d results across window, limit and increment settings",
             events_in, verdicts_out);
    $display("%0d assessments, %0d add requests, %0d delete requests",
             assessments, adds, deletes);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("neighbor_cell_usage_monitor_core_tb passed");
    end else begin
      $display("neighbor_cell_usage_monitor_core_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ncum_pkg.sv
rtl/core/ncum_assess.sv
rtl/core/neighbor_cell_usage_monitor_core.sv
tb/neighbor_cell_usage_monitor_core_tb.sv
